// ===== hdl/lom_pkg.sv =====
package lom_pkg;

    localparam int BOOK_SLOTS = 32;
    localparam int SLOT_W     = $clog2(BOOK_SLOTS);
    localparam int SCNT_W     = $clog2(BOOK_SLOTS + 1);

    // Packed slot entry: side, price, remaining, maker id, arrival.
    typedef struct packed {
        logic        side;
        logic [31:0] price;
        logic [31:0] remaining;
        logic [31:0] maker_id;
        logic [31:0] arrival;
    } slot_t;

    localparam int SLOT_BITS = $bits(slot_t);

    typedef enum logic [2:0] {
        KIND_TRADE    = 3'd0,
        KIND_RESTED   = 3'd1,
        KIND_DONE     = 3'd2,
        KIND_REJECTED = 3'd3,
        KIND_FULL     = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_LAST,
        ST_FILL,
        ST_CLOSE,
        ST_OUT
    } state_t;

endpackage

// ===== hdl/lom_ram.sv =====
module lom_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/limit_order_matcher.sv =====
// Limit order matcher. Each request on the s_axis side is one incoming limit
// order; the block matches it against a book of BOOK_SLOTS resting slots in
// price-time priority and answers with zero or more trade results followed by
// one closing status result (rested, done, rejected or book full), the closing
// result carrying tlast. Matching is done by one compare unit that walks the
// slot table held in a RAM with a registered read, one slot per cycle. Each
// fill is one scan of the whole table, an update step that writes the slot
// back and loads the trade, the handover of the trade and a restart of the
// scan. The last scan finds nothing more to fill and is followed by the
// closing step, the handover of the closing result and the return to idle.
// A rejected order skips the scan: its result is loaded on acceptance and
// handed over. A receiver that holds a result off delays all of this.
// The block takes no new request until the closing result has been accepted.
// Valid bits live in flip-flops and are cleared at reset; the slot payload
// RAM needs no clearing pass. The symbol register sym_reg is written through
// cfg_we/cfg_data; the user must write it only while the block is idle, which
// the block itself does not enforce.
module limit_order_matcher (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [15:0]  cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // side[0], limit_price[32:1], order_quantity[64:33], id[96:65],
    // symbol_code[112:97], order_type[113], tif[114], zero pad
    input  logic [119:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // result_kind[2:0], trade_sequence[34:3], taker_id[66:35],
    // maker_id[98:67], fill_price[130:99], fill_qty[162:131],
    // qty_left[194:163], zero pad
    output logic [199:0] m_axis_tdata,
    output logic         m_axis_tlast
);
    import lom_pkg::*;

    logic [15:0] sym_reg;
    state_t      state_reg, state_next;

    logic        side_reg;
    logic [31:0] price_reg, rem_reg, id_reg;
    logic        tif_reg;

    logic [BOOK_SLOTS-1:0] valid_reg, valid_next;
    logic [31:0] arr_cnt_reg, arr_cnt_next;
    logic [31:0] trd_cnt_reg, trd_cnt_next;

    logic [SCNT_W-1:0] idx_reg, idx_next;   // scan read address counter
    logic [SLOT_W-1:0] cmp_idx_reg;         // slot whose data is on rdata
    logic              found_reg, found_next;
    logic [SLOT_W-1:0] best_idx_reg, best_idx_next;
    slot_t             best_reg, best_next;
    logic [31:0]       best_age_reg, best_age_next;

    logic [2:0]  o_kind_reg;
    logic [31:0] o_seq_reg, o_maker_reg, o_price_reg, o_qty_reg, o_rem_reg;
    logic        o_last_reg;
    logic        o_valid_reg;

    // RAM port
    logic              ram_we;
    logic [SLOT_W-1:0] ram_waddr, ram_raddr;
    slot_t             ram_wdata, ram_rdata;

    lom_ram #(.WIDTH(SLOT_BITS), .DEPTH(BOOK_SLOTS)) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Input unpack
    logic        in_side, in_type, in_tif;
    logic [31:0] in_price, in_qty, in_id;
    logic [15:0] in_sym;
    assign in_side  = s_axis_tdata[0];
    assign in_price = s_axis_tdata[32:1];
    assign in_qty   = s_axis_tdata[64:33];
    assign in_id    = s_axis_tdata[96:65];
    assign in_sym   = s_axis_tdata[112:97];
    assign in_type  = s_axis_tdata[113];
    assign in_tif   = s_axis_tdata[114];

    assign s_axis_tready = (state_reg == ST_IDLE) && !o_valid_reg;
    assign m_axis_tvalid = o_valid_reg;
    assign m_axis_tlast  = o_last_reg;
    assign m_axis_tdata  = {5'd0, o_rem_reg, o_qty_reg, o_price_reg, o_maker_reg,
                            id_reg, o_seq_reg, o_kind_reg};

    // Shared compare unit: candidate on rdata against the running best.
    logic [31:0] cand_age;
    logic        cand_ok, cand_better;
    assign cand_age = arr_cnt_reg - ram_rdata.arrival;
    assign cand_ok  = valid_reg[cmp_idx_reg] && (ram_rdata.side != side_reg);
    always_comb
    begin
        if (!found_reg)
        begin
            cand_better = 1'b1;
        end
        else if (ram_rdata.price != best_reg.price)
        begin
            cand_better = side_reg ? (ram_rdata.price > best_reg.price)
                                   : (ram_rdata.price < best_reg.price);
        end
        else
        begin
            cand_better = cand_age > best_age_reg;
        end
    end

    // Lowest free slot.
    logic              free_any;
    logic [SLOT_W-1:0] free_idx;
    always_comb
    begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = BOOK_SLOTS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_any = 1'b1;
                free_idx = SLOT_W'(i);
            end
        end
    end

    logic        crosses;
    logic [31:0] fill_q;
    assign crosses = side_reg ? (price_reg <= best_reg.price)
                              : (price_reg >= best_reg.price);
    assign fill_q  = (rem_reg < best_reg.remaining) ? rem_reg : best_reg.remaining;

    logic        ld_out;
    logic [2:0]  ld_kind;
    logic [31:0] ld_seq, ld_maker, ld_price, ld_qty, ld_rem;
    logic        ld_last;
    logic        ld_in;

    always_comb
    begin
        state_next    = state_reg;
        valid_next    = valid_reg;
        arr_cnt_next  = arr_cnt_reg;
        trd_cnt_next  = trd_cnt_reg;
        idx_next      = idx_reg;
        found_next    = found_reg;
        best_idx_next = best_idx_reg;
        best_next     = best_reg;
        best_age_next = best_age_reg;
        ram_we        = 1'b0;
        ram_waddr     = best_idx_reg;
        ram_wdata     = best_reg;
        ram_raddr     = idx_reg[SLOT_W-1:0];
        ld_out        = 1'b0;
        ld_kind       = KIND_DONE;
        ld_seq        = '0;
        ld_maker      = '0;
        ld_price      = '0;
        ld_qty        = '0;
        ld_rem        = rem_reg;
        ld_last       = 1'b1;
        ld_in         = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid && s_axis_tready)
                begin
                    ld_in = 1'b1;
                    if (in_sym != sym_reg || in_type || in_qty == '0 || in_price == '0)
                    begin
                        ld_out     = 1'b1;
                        ld_kind    = KIND_REJECTED;
                        ld_rem     = in_qty;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        idx_next   = SCNT_W'(1);
                        ram_raddr  = '0;
                        found_next = 1'b0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (cand_ok && cand_better)
                begin
                    found_next    = 1'b1;
                    best_idx_next = cmp_idx_reg;
                    best_next     = ram_rdata;
                    best_age_next = cand_age;
                end
                idx_next = idx_reg + SCNT_W'(1);
                if (idx_reg == SCNT_W'(BOOK_SLOTS))
                begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL:
            begin
                if (found_reg && crosses && rem_reg != '0)
                begin
                    trd_cnt_next       = trd_cnt_reg + 32'd1;
                    best_next.remaining = best_reg.remaining - fill_q;
                    ram_we             = 1'b1;
                    ram_wdata          = best_next;
                    if (best_reg.remaining == fill_q)
                    begin
                        valid_next[best_idx_reg] = 1'b0;
                    end
                    ld_out   = 1'b1;
                    ld_kind  = KIND_TRADE;
                    ld_seq   = trd_cnt_next;
                    ld_maker = best_reg.maker_id;
                    ld_price = best_reg.price;
                    ld_qty   = fill_q;
                    ld_rem   = rem_reg - fill_q;
                    ld_last  = 1'b0;
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_CLOSE;
                end
            end
            ST_CLOSE:
            begin
                ld_out     = 1'b1;
                state_next = ST_OUT;
                if (rem_reg != '0 && !tif_reg)
                begin
                    if (free_any)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = free_idx;
                        ram_wdata = '{side: side_reg, price: price_reg,
                                      remaining: rem_reg, maker_id: id_reg,
                                      arrival: arr_cnt_reg};
                        valid_next[free_idx] = 1'b1;
                        arr_cnt_next = arr_cnt_reg + 32'd1;
                        ld_kind = KIND_RESTED;
                    end
                    else
                    begin
                        ld_kind = KIND_FULL;
                    end
                end
            end
            ST_OUT:
            begin
                if (!o_valid_reg)
                begin
                    if (o_last_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = SCNT_W'(1);
                        ram_raddr  = '0;
                        found_next = 1'b0;
                        state_next = ST_SCAN;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            sym_reg     <= '0;
            valid_reg   <= '0;
            arr_cnt_reg <= '0;
            trd_cnt_reg <= '0;
            o_valid_reg <= 1'b0;
            o_last_reg  <= 1'b0;
            found_reg   <= 1'b0;
            idx_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            arr_cnt_reg <= arr_cnt_next;
            trd_cnt_reg <= trd_cnt_next;
            found_reg   <= found_next;
            idx_reg     <= idx_next;
            if (cfg_we)
            begin
                sym_reg <= cfg_data;
            end
            if (ld_out)
            begin
                o_valid_reg <= 1'b1;
                o_last_reg  <= ld_last;
            end
            else if (m_axis_tready)
            begin
                o_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg  <= ram_raddr;
        best_idx_reg <= best_idx_next;
        best_reg     <= best_next;
        best_age_reg <= best_age_next;
        // A rejected order loads and answers in the same cycle; its quantity
        // is then both the input and the reported remainder.
        if (ld_in)
        begin
            side_reg  <= in_side;
            price_reg <= in_price;
            rem_reg   <= in_qty;
            id_reg    <= in_id;
            tif_reg   <= in_tif;
        end
        else if (ld_out)
        begin
            rem_reg <= ld_rem;
        end
        if (ld_out)
        begin
            o_kind_reg  <= ld_kind;
            o_seq_reg   <= ld_seq;
            o_maker_reg <= ld_maker;
            o_price_reg <= ld_price;
            o_qty_reg   <= ld_qty;
            o_rem_reg   <= ld_rem;
        end
    end

endmodule

// ===== hdl/lom_checker.sv =====
module lom_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [199:0] m_axis_tdata,
    input logic         m_axis_tlast
);
    import lom_pkg::*;

    // A request is never taken while a result is still pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !m_axis_tvalid)
        else $error("request accepted with result pending");

    // A stalled result holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("stalled result changed");

    // Trades never close an order, closing results always do.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ((m_axis_tdata[2:0] == KIND_TRADE) != m_axis_tlast))
        else $error("tlast does not match result kind");

    // Non-trade results carry zero quantity.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[162:131] == 32'd0)
        else $error("closing result with nonzero trade quantity");

endmodule

bind limit_order_matcher lom_checker u_lom_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== tb/limit_order_matcher_tb.sv =====
module limit_order_matcher_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lom_pkg::*;

    // One result of the matcher as the checker sees it.
    typedef struct {
        kind_t       kind;
        logic [31:0] seq;
        logic [31:0] taker;
        logic [31:0] maker;
        logic [31:0] price;
        logic [31:0] qty;
        logic [31:0] rem;
        logic        last;
    } fill_result_t;

    localparam int CYCLE_LIMIT = 1500000;

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic [15:0]  cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [119:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [199:0] m_axis_tdata;
    logic         m_axis_tlast;

    // Shadow copy of the book, the symbol register and both counters.
    logic        book_valid [BOOK_SLOTS];
    slot_t       book_entry [BOOK_SLOTS];
    logic [31:0] next_arrival;
    logic [31:0] next_trade;
    logic [15:0] shadow_symbol;

    fill_result_t expected_fills[$];
    int  errors;
    int  cycles;
    int  hold_cycles;
    logic [15:0] cur_symbol;
    int  next_id;

    limit_order_matcher dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // The watchdog ends a run that hangs.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout at %0t", $time);
            $display("status: fail");
            $finish;
        end
    end

    // Picks the best opposite slot: best price first, then the oldest
    // arrival, then the lowest index. Returns -1 when nothing rests on the opposite side.
    function automatic int best_opposite(logic taker_side);
        int best;
        logic [31:0] best_price;
        logic [31:0] best_age;
        logic [31:0] age;
        logic better;
        best = -1;
        best_price = '0;
        best_age = '0;
        for (int i = 0; i < BOOK_SLOTS; i++)
        begin
            if (!book_valid[i] || book_entry[i].side == taker_side)
                continue;
            age = next_arrival - book_entry[i].arrival;
            if (best < 0)
                better = 1'b1;
            else if (book_entry[i].price != best_price)
                better = (taker_side == 1'b0) ? (book_entry[i].price < best_price)
                                              : (book_entry[i].price > best_price);
            else
                better = age > best_age;
            if (better)
            begin
                best = i;
                best_price = book_entry[i].price;
                best_age = age;
            end
        end
        return best;
    endfunction

    function automatic fill_result_t status_result(kind_t kind, logic [31:0] taker,
                                                   logic [31:0] rem);
        fill_result_t r;
        r.kind = kind;
        r.seq = '0;
        r.taker = taker;
        r.maker = '0;
        r.price = '0;
        r.qty = '0;
        r.rem = rem;
        r.last = 1'b1;
        return r;
    endfunction

    // Matches one order against the shadow book and queues every result
    // that it should produce: the trades, then one closing status.
    function automatic void match_order(logic [119:0] order);
        logic        side;
        logic [31:0] limit;
        logic [31:0] rem;
        logic [31:0] id;
        logic [15:0] sym;
        logic        otype;
        logic        ioc;
        logic [31:0] q;
        fill_result_t r;
        int n;
        int s;
        int free_slot;
        side  = order[0];
        limit = order[32:1];
        rem   = order[64:33];
        id    = order[96:65];
        sym   = order[112:97];
        otype = order[113];
        ioc   = order[114];
        if (sym != shadow_symbol || otype || rem == 0 || limit == 0)
        begin
            expected_fills.insert(expected_fills.size(),
                                  status_result(KIND_REJECTED, id, rem));
            return;
        end
        n = 0;
        while (rem != 0 && n < BOOK_SLOTS)
        begin
            s = best_opposite(side);
            if (s < 0)
                break;
            if (side == 1'b0 ? (limit < book_entry[s].price)
                             : (limit > book_entry[s].price))
                break;
            q = (rem < book_entry[s].remaining) ? rem : book_entry[s].remaining;
            next_trade++;
            rem -= q;
            book_entry[s].remaining -= q;
            r.kind = KIND_TRADE;
            r.seq = next_trade;
            r.taker = id;
            r.maker = book_entry[s].maker_id;
            r.price = book_entry[s].price;
            r.qty = q;
            r.rem = rem;
            r.last = 1'b0;
            expected_fills.insert(expected_fills.size(), r);
            n++;
            if (book_entry[s].remaining == 0)
                book_valid[s] = 1'b0;
        end
        if (rem != 0 && !ioc)
        begin
            free_slot = -1;
            for (int i = 0; i < BOOK_SLOTS; i++)
            begin
                if (!book_valid[i])
                begin
                    free_slot = i;
                    break;
                end
            end
            if (free_slot < 0)
                expected_fills.insert(expected_fills.size(),
                                      status_result(KIND_FULL, id, rem));
            else
            begin
                book_valid[free_slot] = 1'b1;
                book_entry[free_slot].side = side;
                book_entry[free_slot].price = limit;
                book_entry[free_slot].remaining = rem;
                book_entry[free_slot].maker_id = id;
                book_entry[free_slot].arrival = next_arrival;
                next_arrival++;
                expected_fills.insert(expected_fills.size(),
                                      status_result(KIND_RESTED, id, rem));
            end
        end
        else
            expected_fills.insert(expected_fills.size(),
                                  status_result(KIND_DONE, id, rem));
    endfunction

    // Sends one order after a random gap. The expected results are queued
    // at the edge where the request is taken, before any result can appear.
    // With no gap the next order follows straight on; the valid line drops
    // only while the sender idles.
    task automatic send_order(logic side, logic [31:0] limit, logic [31:0] qty,
                              logic [31:0] id, logic [15:0] sym, logic otype,
                              logic ioc, bit allow_gap = 1'b1);
        logic [119:0] order;
        int gap;
        order = {5'b0, ioc, otype, sym, id, qty, limit, side};
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
        if (!allow_gap)
            gap = 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tdata <= order;
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        match_order(order);
        @(negedge clk);
    endtask

    // Waits until every expected result has come, then lets a closing pass
    // of the block run out before anything else happens.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (expected_fills.size() != 0)
            @(negedge clk);
        repeat (2 * (BOOK_SLOTS + 4)) @(negedge clk);
    endtask

    task automatic write_symbol(logic [15:0] value);
        cfg_data <= value;
        cfg_we <= 1'b1;
        @(negedge clk);
        cfg_we <= 1'b0;
        shadow_symbol = value;
        cur_symbol = value;
    endtask

    function automatic logic [31:0] fresh_id();
        next_id++;
        return next_id;
    endfunction

    // Receiver: a random stall before each result, with calm stretches,
    // plus a long hold-off that the pressure test asks for.
    initial
    begin
        int stall;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_cycles--;
            end
            else if (m_axis_tready && !m_axis_tvalid)
                ;
            else
            begin
                stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16);
                if (stall > 0)
                begin
                    m_axis_tready <= 1'b0;
                    repeat (stall - 1) @(negedge clk);
                end
                else
                    m_axis_tready <= 1'b1;
                if (stall > 0)
                begin
                    @(negedge clk);
                    m_axis_tready <= 1'b1;
                end
            end
        end
    end

    // Result checker: each accepted result against the oldest expectation.
    always @(posedge clk)
    begin
        fill_result_t want;
        logic [199:0] got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata;
            if (expected_fills.size() == 0)
            begin
                $display("%0t unexpected result kind %0d", $time, got[2:0]);
                errors++;
            end
            else
            begin
                want = expected_fills.pop_front();
                if (got[2:0] !== want.kind)
                begin
                    $display("%0t kind: expected %0d, actual %0d", $time, want.kind, got[2:0]);
                    errors++;
                end
                if (got[34:3] !== want.seq)
                begin
                    $display("%0t sequence: expected %0d, actual %0d", $time, want.seq,
                             got[34:3]);
                    errors++;
                end
                if (got[66:35] !== want.taker)
                begin
                    $display("%0t taker: expected %0d, actual %0d", $time, want.taker,
                             got[66:35]);
                    errors++;
                end
                if (got[98:67] !== want.maker)
                begin
                    $display("%0t maker: expected %0d, actual %0d", $time, want.maker,
                             got[98:67]);
                    errors++;
                end
                if (got[130:99] !== want.price)
                begin
                    $display("%0t price: expected %0d, actual %0d", $time, want.price,
                             got[130:99]);
                    errors++;
                end
                if (got[162:131] !== want.qty)
                begin
                    $display("%0t quantity: expected %0d, actual %0d", $time, want.qty,
                             got[162:131]);
                    errors++;
                end
                if (got[194:163] !== want.rem)
                begin
                    $display("%0t remaining: expected %0d, actual %0d", $time, want.rem,
                             got[194:163]);
                    errors++;
                end
                if (got[199:195] !== 5'b0)
                begin
                    $display("%0t pad: expected 0, actual %0h", $time, got[199:195]);
                    errors++;
                end
                if (m_axis_tlast !== want.last)
                begin
                    $display("%0t last: expected %0b, actual %0b", $time, want.last,
                             m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    // Rejections and the extremes of every field on an empty book.
    task automatic test_rejects();
        send_order(1'b0, 32'd100, 32'd5, fresh_id(), cur_symbol ^ 16'hFFFF, 1'b0, 1'b0);
        send_order(1'b1, 32'd100, 32'd5, fresh_id(), cur_symbol, 1'b1, 1'b0);
        send_order(1'b0, 32'd100, 32'd0, fresh_id(), cur_symbol, 1'b0, 1'b1);
        send_order(1'b1, 32'd0, 32'd7, 32'hFFFF_FFFF, cur_symbol, 1'b0, 1'b0);
        send_order(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, cur_symbol, 1'b1, 1'b1);
        drain_results();
    endtask

    // Resting, full fills, partial fills, price and time priority, IOC.
    task automatic test_matching();
        send_order(1'b1, 32'd105, 32'd10, fresh_id(), cur_symbol, 1'b0, 1'b0);
        send_order(1'b1, 32'd103, 32'd4, fresh_id(), cur_symbol, 1'b0, 1'b0);
        send_order(1'b1, 32'd103, 32'd6, fresh_id(), cur_symbol, 1'b0, 1'b0);
        // Crosses both asks at 103 in arrival order and part of the 105 one.
        send_order(1'b0, 32'd105, 32'd12, fresh_id(), cur_symbol, 1'b0, 1'b1);
        // Does not cross: rests as a bid.
        send_order(1'b0, 32'd90, 32'd3, fresh_id(), cur_symbol, 1'b0, 1'b0);
        // IOC that does not cross is dropped.
        send_order(1'b1, 32'd95, 32'd2, fresh_id(), cur_symbol, 1'b0, 1'b1);
        // Sell sweeps the bid, then the remainder rests.
        send_order(1'b1, 32'd1, 32'd9, fresh_id(), cur_symbol, 1'b0, 1'b0);
        // Exact fill of the resting asks.
        send_order(1'b0, 32'hFFFF_FFFF, 32'd14, fresh_id(), cur_symbol, 1'b0, 1'b0);
        send_order(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, fresh_id(), cur_symbol, 1'b0, 1'b0);
        send_order(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, fresh_id(), cur_symbol, 1'b0, 1'b1);
        drain_results();
    endtask

    // Fills every slot, overflows it, then sweeps the whole book in one order.
    task automatic test_full_book();
        for (int i = 0; i < BOOK_SLOTS + 2; i++)
            send_order(1'b0, 32'd50 + (i % 5), 32'd1 + i, fresh_id(), cur_symbol,
                       1'b0, 1'b0);
        send_order(1'b1, 32'd1, 32'hFFFF_FFFF, fresh_id(), cur_symbol, 1'b0, 1'b1);
        drain_results();
    endtask

    // The receiver holds off for a long time while orders keep coming.
    task automatic test_backpressure();
        hold_cycles = 600;
        for (int i = 0; i < 12; i++)
            send_order(i[0], 32'd200 + $urandom_range(0, 3), $urandom_range(1, 20),
                       fresh_id(), cur_symbol, 1'b0, 1'b0, 1'b0);
        drain_results();
    endtask

    // Random orders: mostly valid and near one price so that they cross.
    task automatic test_random(int count);
        logic [31:0] price;
        logic [31:0] qty;
        logic [15:0] sym;
        logic otype;
        int pick;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 19);
            price = 32'd1000 + $urandom_range(0, 8) - 4;
            qty = $urandom_range(1, 40);
            sym = cur_symbol;
            otype = 1'b0;
            if (pick == 0)
                sym = 16'($urandom);
            else if (pick == 1)
                otype = 1'b1;
            else if (pick == 2)
                qty = $urandom;
            else if (pick == 3)
                price = $urandom;
            else if (pick == 4)
                qty = 32'd0;
            send_order(1'($urandom_range(0, 1)), price, qty, $urandom, sym, otype,
                       $urandom_range(0, 3) == 0);
        end
        drain_results();
    endtask

    initial
    begin
        errors = 0;
        cycles = 0;
        hold_cycles = 0;
        next_id = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        shadow_symbol = '0;
        cur_symbol = '0;
        next_arrival = '0;
        next_trade = '0;
        for (int i = 0; i < BOOK_SLOTS; i++)
        begin
            book_valid[i] = 1'b0;
            book_entry[i] = '0;
        end
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // The reset symbol of zero is used first, then other settings.
        test_rejects();
        test_matching();
        write_symbol(16'hFFFF);
        test_rejects();
        test_full_book();
        write_symbol(16'h1234);
        test_backpressure();
        test_random(77);
        write_symbol(16'($urandom));
        test_random(77);

        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/lom_pkg.sv
hdl/lom_ram.sv
hdl/limit_order_matcher.sv
hdl/lom_checker.sv
tb/limit_order_matcher_tb.sv
